/* rtl/ofd_pkg.sv */
// ofd_pkg: shared widths, constants, register indexes and the fold cell record
// for the octahedral fold distance estimator. No dependencies.
`default_nettype none
package ofd_pkg;
  localparam int FRAC_BITS = 16;
  localparam int CW        = 32;                    // coordinate width
  localparam int SW        = 31;                    // scale / derivative width
  localparam int KW        = 20;                    // fold scale width
  localparam int IXW       = 3;                     // register index width
  localparam int DVW       = CW + 1 + FRAC_BITS;    // divider dividend / quotient width
  localparam int SQW       = 2 * CW;                // square width
  localparam int RW        = CW;                    // root width
  localparam int VW        = CW + KW - FRAC_BITS + 2;

  localparam logic [SW-1:0]        ONE_Q   = SW'(1) << FRAC_BITS;
  localparam logic signed [CW-1:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [CW-1:0] S32_MIN = 32'sh80000000;

  typedef enum logic [IXW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_WORLD_SC = 3'd3,
    REG_FOLD_SC  = 3'd4,
    REG_BAILOUT  = 3'd5,
    REG_ITER_CNT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic [SW-1:0]        dr;
    logic                 run;
    logic                 sat;
  } cell_t;

  function automatic logic [CW-1:0] mag32(input logic signed [CW-1:0] v);
    logic [CW-1:0] u;
    u = v;
    mag32 = u[CW-1] ? (~u + CW'(1)) : u;
  endfunction

  function automatic logic [SQW-1:0] sq32(input logic signed [CW-1:0] v);
    logic [CW-1:0] m;
    m = mag32(v);
    sq32 = SQW'(m) * SQW'(m);
  endfunction
endpackage
`default_nettype wire

/* rtl/ofd_div.sv */
// ofd_div: restoring bit-serial divider, one quotient bit per cycle.
// Depends on ofd_pkg.
`default_nettype none
module ofd_div import ofd_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [DVW-1:0] dividend,
  input  wire logic [SW-1:0]  divisor,
  output logic                done,
  output logic [DVW-1:0]      quot
);
  localparam int CNW = $clog2(DVW + 1);

  logic [DVW-1:0] q_r;
  logic [SW-1:0]  rem_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [SW:0]    trial;
  logic [SW:0]    diff;
  logic           take;

  always_comb begin
    trial = {rem_r, q_r[DVW-1]};
    take  = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(DVW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNW'(1);
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= take ? diff[SW-1:0] : trial[SW-1:0];
      q_r   <= {q_r[DVW-2:0], take};
    end
  end

  assign done = done_r;
  assign quot = q_r;
endmodule
`default_nettype wire

/* rtl/ofd_sqrt.sv */
// ofd_sqrt: digit-by-digit integer square root, one root bit per cycle.
// Depends on ofd_pkg.
`default_nettype none
module ofd_sqrt import ofd_pkg::*; (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire logic [SQW-1:0] radicand,
  output logic                done,
  output logic [RW-1:0]       root
);
  localparam int CNW = $clog2(RW + 1);

  logic [SQW-1:0]  rad_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [CNW-1:0]  cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [RW+3:0]   rem2;
  logic [RW+3:0]   trial;
  logic            take;

  always_comb begin
    rem2  = {rem_r, rad_r[SQW-1:SQW-2]};
    trial = (RW+4)'({root_r, 2'b01});
    take  = rem2 >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNW'(RW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNW'(1);
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r  <= {rad_r[SQW-3:0], 2'b00};
      rem_r  <= take ? (RW+2)'(rem2 - trial) : (RW+2)'(rem2);
      root_r <= {root_r[RW-2:0], take};
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule
`default_nettype wire

/* rtl/ofd_cell.sv */
// ofd_cell: one fold iteration of the chain: bailout test on the incoming point,
// abs + descending sort, scale-and-offset, derivative update. Depends on ofd_pkg.
`default_nettype none
module ofd_cell import ofd_pkg::*; #(
  parameter int IDX = 0,
  parameter int IW  = 5
) (
  input  wire logic            clk,
  input  wire logic [IW-1:0]   n_iter,
  input  wire logic [KW-1:0]   k,
  input  wire logic [2*SW-1:0] bail2,
  input  wire cell_t           din,
  output cell_t                dout
);
  localparam logic signed [VW-1:0] VMAX = VW'(S32_MAX);
  localparam logic signed [VW-1:0] VMIN = VW'(S32_MIN);
  localparam int PW = CW + KW;
  localparam int DW = SW + KW;

  cell_t                   cell_r;
  logic [CW-1:0]           a [0:2];
  logic [CW-1:0]           t;
  logic [PW-1:0]           p [0:2];
  logic signed [VW-1:0]    v [0:2];
  logic signed [CW-1:0]    zc [0:2];
  logic [2:0]              zs;
  logic signed [VW-1:0]    koff;
  logic [DW-1:0]           pd;
  logic [DW-FRAC_BITS-1:0] sd;
  logic [SW-1:0]           dr_new;
  logic                    dr_sat;
  logic [SQW+1:0]          sum;
  logic                    go;

  always_comb begin
    t    = '0;
    a[0] = mag32(din.x);
    a[1] = mag32(din.y);
    a[2] = mag32(din.z);
    if (a[0] < a[1]) begin
      t = a[0]; a[0] = a[1]; a[1] = t;
    end
    if (a[0] < a[2]) begin
      t = a[0]; a[0] = a[2]; a[2] = t;
    end
    if (a[1] < a[2]) begin
      t = a[1]; a[1] = a[2]; a[2] = t;
    end
    koff = $signed(VW'(k)) - $signed(VW'(ONE_Q));
    for (int i = 0; i < 3; i++) begin
      p[i] = PW'(a[i]) * PW'(k);
      v[i] = $signed(VW'(p[i][PW-1:FRAC_BITS])) - koff;
      if (v[i] > VMAX) begin
        zc[i] = S32_MAX;
        zs[i] = 1'b1;
      end else if (v[i] < VMIN) begin
        zc[i] = S32_MIN;
        zs[i] = 1'b1;
      end else begin
        zc[i] = v[i][CW-1:0];
        zs[i] = 1'b0;
      end
    end
    pd = DW'(din.dr) * DW'(k);
    sd = pd[DW-1:FRAC_BITS];
    dr_sat = sd > (DW-FRAC_BITS)'(S32_MAX);
    dr_new = dr_sat ? SW'(S32_MAX) : sd[SW-1:0];
    sum = (SQW+2)'(sq32(din.x)) + (SQW+2)'(sq32(din.y)) + (SQW+2)'(sq32(din.z));
    go = din.run && (IW'(IDX) < n_iter) && ((IDX == 0) || (sum <= (SQW+2)'(bail2)));
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cell_r.x   <= zc[0];
      cell_r.y   <= zc[1];
      cell_r.z   <= zc[2];
      cell_r.dr  <= dr_new;
      cell_r.run <= 1'b1;
      cell_r.sat <= din.sat | (|zs) | dr_sat;
    end else begin
      cell_r <= '{x: din.x, y: din.y, z: din.z, dr: din.dr, run: 1'b0, sat: din.sat};
    end
  end

  assign dout = cell_r;
endmodule
`default_nettype wire

/* rtl/octahedral_fold_fractal_distance.sv */
// Octahedral fold fractal distance estimator, top level: config registers,
// sequencer, fold cell chain. Depends on ofd_pkg, ofd_div, ofd_sqrt, ofd_cell.
//
// One point is processed at a time; nothing is kept between points. While the
// result side keeps up, the block returns to idle in the same cycle that a
// result becomes valid, so the next point can be taken then. Three position
// divisions and the final distance division go through one shared bit-serial
// divider, the fold iterations pass through a chain of MAX_ITERATIONS cells at
// one cell per cycle, the length comes from a 32-step square root, plus a state
// for the sum of squares and states for the scale multiply and output. A
// finished result waits in the output register while the next point is taken;
// a result still waiting when the next one is done holds the block until it is
// taken. Configuration writes are accepted any time but must only be made while
// idle.
`default_nettype none
module octahedral_fold_fractal_distance import ofd_pkg::*; #(
  parameter int MAX_ITERATIONS = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [IXW-1:0] cfg_index,
  input  wire logic [CW-1:0]  cfg_wdata,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [CW-1:0]  in_pos_x,
  input  wire logic [CW-1:0]  in_pos_y,
  input  wire logic [CW-1:0]  in_pos_z,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [SW-1:0]       out_distance,
  output logic                out_saturated
);
  localparam int IW  = $clog2(MAX_ITERATIONS + 1);
  localparam int HI  = DVW / 2;
  localparam int LO  = DVW - HI;
  localparam int PRW = DVW + SW;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_CHAIN = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_ROOT  = 9'b000010000,
    S_RDIV  = 9'b000100000,
    S_MLO   = 9'b001000000,
    S_MHI   = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t               state_r;
  logic signed [CW-1:0] ctr_r [0:2];
  logic [SW-1:0]        ws_r;
  logic [KW-1:0]        k_r;
  logic [SW-1:0]        bail_r;
  logic [4:0]           iter_r;
  logic [2*SW-1:0]      bail2_r;
  logic [IW-1:0]        n_r;
  logic [SW-1:0]        wsafe;

  logic [CW:0]          mag_r [0:2];
  logic [2:0]           neg_r;
  logic signed [CW-1:0] loc_r [0:2];
  logic [1:0]           axis_r;
  logic                 sat_r;
  logic                 issue_r;
  logic [IW-1:0]        cnt_r;
  logic [SQW-1:0]       sum_r;
  logic [SW-1:0]        dr_r;
  logic [RW-1:0]        len_r;
  logic [DVW-1:0]       ratio_r;
  logic [LO+SW-1:0]     plo_r;
  logic [HI+SW-1:0]     phi_r;
  logic                 out_valid_r;
  logic [SW-1:0]        out_distance_r;
  logic                 out_saturated_r;

  logic signed [CW-1:0] pos_w [0:2];
  logic signed [CW:0]   diff_w [0:2];
  logic [DVW-1:0]       div_dividend;
  logic [SW-1:0]        div_divisor;
  logic                 div_start;
  logic                 div_done;
  logic [DVW-1:0]       div_quot;
  logic                 rt_start;
  logic                 rt_done;
  logic [RW-1:0]        rt_root;
  logic [PRW-1:0]       prod;
  cell_t                chain_w [0:MAX_ITERATIONS];
  logic signed [CW-1:0] loc_new;
  logic                 loc_sat;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r[0] <= '0;
      ctr_r[1] <= '0;
      ctr_r[2] <= '0;
      ws_r     <= ONE_Q;
      k_r      <= KW'(3) << FRAC_BITS;
      bail_r   <= SW'(10) << FRAC_BITS;
      iter_r   <= 5'd8;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_CENTER_X: ctr_r[0] <= cfg_wdata;
        REG_CENTER_Y: ctr_r[1] <= cfg_wdata;
        REG_CENTER_Z: ctr_r[2] <= cfg_wdata;
        REG_WORLD_SC: ws_r     <= cfg_wdata[SW-1:0];
        REG_FOLD_SC:  k_r      <= cfg_wdata[KW-1:0];
        REG_BAILOUT:  bail_r   <= cfg_wdata[SW-1:0];
        REG_ITER_CNT: iter_r   <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    bail2_r <= (2*SW)'(bail_r) * (2*SW)'(bail_r);
    if (32'(iter_r) > MAX_ITERATIONS) begin
      n_r <= IW'(MAX_ITERATIONS);
    end else begin
      n_r <= IW'(iter_r);
    end
  end

  assign wsafe = (ws_r == '0) ? SW'(1) : ws_r;

  // divider (shared by all divisions) and square root
  always_comb begin
    if (state_r == S_RDIV) begin
      div_dividend = DVW'({len_r, {FRAC_BITS{1'b0}}});
      div_divisor  = (dr_r == '0) ? SW'(1) : dr_r;
    end else begin
      div_dividend = {mag_r[axis_r], {FRAC_BITS{1'b0}}};
      div_divisor  = wsafe;
    end
    div_start = issue_r && (state_r == S_DIV || state_r == S_RDIV);
    rt_start  = issue_r && (state_r == S_ROOT);
  end

  ofd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot)
  );

  ofd_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rt_start),
    .radicand (sum_r),
    .done     (rt_done),
    .root     (rt_root)
  );

  // fold chain
  assign chain_w[0] = '{x: loc_r[0], y: loc_r[1], z: loc_r[2], dr: ONE_Q,
                        run: 1'b1, sat: sat_r};

  for (genvar g = 0; g < MAX_ITERATIONS; g++) begin : g_cell
    ofd_cell #(.IDX(g), .IW(IW)) u_cell (
      .clk    (clk),
      .n_iter (n_r),
      .k      (k_r),
      .bail2  (bail2_r),
      .din    (chain_w[g]),
      .dout   (chain_w[g+1])
    );
  end

  // local point clamp
  always_comb begin
    loc_sat = 1'b0;
    if (!neg_r[axis_r]) begin
      if (div_quot > DVW'(S32_MAX)) begin
        loc_new = S32_MAX;
        loc_sat = 1'b1;
      end else begin
        loc_new = div_quot[CW-1:0];
      end
    end else begin
      if (div_quot > (DVW'(1) << (CW - 1))) begin
        loc_new = S32_MIN;
        loc_sat = 1'b1;
      end else begin
        loc_new = ~div_quot[CW-1:0] + CW'(1);
      end
    end
  end

  assign pos_w[0] = in_pos_x;
  assign pos_w[1] = in_pos_y;
  assign pos_w[2] = in_pos_z;
  assign prod = PRW'(plo_r) + (PRW'(phi_r) << LO);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      diff_w[i] = $signed({pos_w[i][CW-1], pos_w[i]}) - $signed({ctr_r[i][CW-1], ctr_r[i]});
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      if (div_start || rt_start) begin
        issue_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            issue_r <= 1'b1;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (axis_r == 2'd2) begin
              state_r <= S_CHAIN;
            end else begin
              issue_r <= 1'b1;
            end
          end
        end
        S_CHAIN: begin
          if (cnt_r == IW'(MAX_ITERATIONS - 1)) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          issue_r <= 1'b1;
          state_r <= S_ROOT;
        end
        S_ROOT: begin
          if (rt_done) begin
            issue_r <= 1'b1;
            state_r <= S_RDIV;
          end
        end
        S_RDIV: begin
          if (div_done) begin
            state_r <= S_MLO;
          end
        end
        S_MLO: state_r <= S_MHI;
        S_MHI: state_r <= S_FIN;
        S_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          for (int i = 0; i < 3; i++) begin
            neg_r[i] <= diff_w[i][CW];
            mag_r[i] <= diff_w[i][CW] ? (~diff_w[i] + (CW+1)'(1)) : diff_w[i];
          end
          axis_r <= 2'd0;
          sat_r  <= 1'b0;
        end
      end
      S_DIV: begin
        cnt_r <= '0;
        if (div_done) begin
          loc_r[axis_r] <= loc_new;
          sat_r         <= sat_r | loc_sat;
          axis_r        <= axis_r + 2'd1;
        end
      end
      S_CHAIN: cnt_r <= cnt_r + IW'(1);
      S_SUM: begin
        sum_r <= sq32(chain_w[MAX_ITERATIONS].x) + sq32(chain_w[MAX_ITERATIONS].y)
               + sq32(chain_w[MAX_ITERATIONS].z);
        dr_r  <= chain_w[MAX_ITERATIONS].dr;
        sat_r <= chain_w[MAX_ITERATIONS].sat;
      end
      S_ROOT: begin
        if (rt_done) begin
          len_r <= rt_root;
        end
      end
      S_RDIV: begin
        if (div_done) begin
          ratio_r <= div_quot;
        end
      end
      S_MLO: plo_r <= (LO+SW)'(ratio_r[LO-1:0]) * (LO+SW)'(wsafe);
      S_MHI: phi_r <= (HI+SW)'(ratio_r[DVW-1:LO]) * (HI+SW)'(wsafe);
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          if (prod[PRW-1:FRAC_BITS+SW] != '0) begin
            out_distance_r  <= SW'(S32_MAX);
            out_saturated_r <= 1'b1;
          end else begin
            out_distance_r  <= prod[FRAC_BITS+SW-1:FRAC_BITS];
            out_saturated_r <= sat_r;
          end
        end
      end
      default: ;
    endcase
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_distance  = out_distance_r;
  assign out_saturated = out_saturated_r;
endmodule
`default_nettype wire

/* rtl/ofd_chk.sv */
// ofd_chk: port-level checks for the fractal distance estimator, bound to the top.
// Depends on ofd_pkg and octahedral_fold_fractal_distance.
`default_nettype none
module ofd_chk import ofd_pkg::*; (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire logic [SW-1:0] out_distance,
  input wire logic          out_saturated
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_distance) && $stable(out_saturated))
    else $error("result changed while stalled");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken while a point is in flight");

  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("new result without return to idle");
endmodule

bind octahedral_fold_fractal_distance ofd_chk u_ofd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_distance  (out_distance),
  .out_saturated (out_saturated)
);
`default_nettype wire

/* bench/octahedral_fold_fractal_distance_test.sv */
// Self-checking bench for octahedral_fold_fractal_distance: drives points over
// valid/ready, predicts each distance in place and compares. Depends on ofd_pkg.
`timescale 1ns / 100ps
module octahedral_fold_fractal_distance_test;
  import ofd_pkg::*;

  localparam int MAX_IT = 16;

  typedef struct {
    logic [SW-1:0] distance;
    logic          saturated;
  } dist_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [IXW-1:0] cfg_index;
  logic [CW-1:0] cfg_wdata;
  logic in_valid, in_ready;
  logic [CW-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic out_valid, out_ready;
  logic [SW-1:0] out_distance;
  logic out_saturated;

  octahedral_fold_fractal_distance dut (.*);

  // shadow of the block's registers
  longint m_cx, m_cy, m_cz;
  longint unsigned m_ws, m_k, m_bail, m_iters;

  dist_t pending_q[$];
  int errors, points, results;
  int send_idle, recv_idle;

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400ms;
    $display("octahedral_fold_fractal_distance_test NOT OK");
    $finish;
  end

  function automatic longint sat32(longint v, ref bit s);
    if (v > 64'sd2147483647) begin
      s = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      s = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint localize(longint p, longint c, longint unsigned ws, ref bit s);
    longint d;
    longint unsigned m;
    d = p - c;
    m = (d < 0) ? longint'(-d) : d;
    m = (m << FRAC_BITS) / ws;
    if (m > (64'd1 << 32)) m = 64'd1 << 32;
    return sat32((d < 0) ? -longint'(m) : longint'(m), s);
  endfunction

  function automatic longint unsigned sqmag(longint v);
    longint unsigned m;
    m = (v < 0) ? -v : v;
    return m * m;
  endfunction

  function automatic dist_t fold_distance(logic [CW-1:0] px, logic [CW-1:0] py,
                                          logic [CW-1:0] pz);
    dist_t r;
    bit s;
    longint unsigned ws, n, bail2, len, dsafe, ratio, dist_v;
    longint x, y, z, t, k, dr;
    s = 0;
    ws = (m_ws != 0) ? m_ws : 1;
    k = m_k;
    x = localize(longint'($signed(px)), m_cx, ws, s);
    y = localize(longint'($signed(py)), m_cy, ws, s);
    z = localize(longint'($signed(pz)), m_cz, ws, s);
    dr = 64'sd1 << FRAC_BITS;
    bail2 = m_bail * m_bail;
    n = (m_iters > MAX_IT) ? MAX_IT : m_iters;
    for (longint unsigned i = 0; i < n; i++) begin
      if (x < 0) x = -x;
      if (y < 0) y = -y;
      if (z < 0) z = -z;
      if (x < y) begin t = x; x = y; y = t; end
      if (x < z) begin t = x; x = z; z = t; end
      if (y < z) begin t = y; y = z; z = t; end
      x = sat32(((x * k) >>> FRAC_BITS) - (k - 65536), s);
      y = sat32(((y * k) >>> FRAC_BITS) - (k - 65536), s);
      z = sat32(((z * k) >>> FRAC_BITS) - (k - 65536), s);
      dr = (dr * k) >>> FRAC_BITS;
      if (dr > 64'sd2147483647) begin
        dr = 64'sd2147483647;
        s = 1;
      end
      if (sqmag(x) + sqmag(y) + sqmag(z) > bail2) break;
    end
    len = root64(sqmag(x) + sqmag(y) + sqmag(z));
    dsafe = (dr > 0) ? dr : 1;
    ratio = (len << FRAC_BITS) / dsafe;
    if (ratio > 64'hffff_ffff_ffff_ffff / ws) begin
      dist_v = 64'h7fff_ffff;
      s = 1;
    end else begin
      dist_v = (ratio * ws) >> FRAC_BITS;
      if (dist_v > 64'h7fff_ffff) begin
        dist_v = 64'h7fff_ffff;
        s = 1;
      end
    end
    r.distance = dist_v[SW-1:0];
    r.saturated = s;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    $display("MISMATCH %s: got %0d want %0d (result %0d)", what, got, want, results);
  endtask

  // result side: random stall plus checking
  always @(posedge clk) begin
    dist_t e;
    if (rst_n && out_valid && out_ready) begin
      results++;
      if (pending_q.size() == 0) begin
        report_mismatch("unexpected result", out_distance, -1);
      end else begin
        e = pending_q.pop_front();
        if (out_distance !== e.distance)
          report_mismatch("distance", out_distance, e.distance);
        if (out_saturated !== e.saturated)
          report_mismatch("saturated", out_saturated, e.saturated);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  task automatic write_reg(reg_idx_t idx, logic [CW-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_CENTER_X: m_cx = longint'($signed(v));
      REG_CENTER_Y: m_cy = longint'($signed(v));
      REG_CENTER_Z: m_cz = longint'($signed(v));
      REG_WORLD_SC: m_ws = v[30:0];
      REG_FOLD_SC:  m_k = v[19:0];
      REG_BAILOUT:  m_bail = v[30:0];
      REG_ITER_CNT: m_iters = v[4:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] py, logic [CW-1:0] pz);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_pos_x <= px;
    in_pos_y <= py;
    in_pos_z <= pz;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(fold_distance(px, py, pz));
    points++;
  endtask

  task automatic drain();
    int guard;
    in_valid <= 0;
    guard = 0;
    while (pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (400) @(posedge clk);
  endtask

  task automatic set_all(logic [CW-1:0] cx, logic [CW-1:0] cy, logic [CW-1:0] cz,
                         logic [CW-1:0] ws, logic [CW-1:0] k, logic [CW-1:0] b,
                         logic [CW-1:0] it);
    drain();
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_WORLD_SC, ws);
    write_reg(REG_FOLD_SC, k);
    write_reg(REG_BAILOUT, b);
    write_reg(REG_ITER_CNT, it);
  endtask

  function automatic logic [CW-1:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0006_0000) - 32'h0003_0000;
      default: return $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  task automatic test_directed();
    logic [CW-1:0] ext[6] = '{32'h8000_0000, 32'h7fff_ffff, 0, 32'hffff_ffff,
                              32'h0001_0000, 32'h0000_8000};
    for (int i = 0; i < 6; i++) send_point(ext[i], ext[5 - i], ext[(i + 2) % 6]);
    send_point(32'h0001_0000, 32'h0003_0000, 32'h0002_0000);
    // zero iterations: plain length of local point
    set_all(0, 0, 0, 32'h0001_0000, 32'h0003_0000, 32'h000a_0000, 0);
    send_point(32'h0003_0000, 32'h0004_0000, 0);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // zero world scale, count above limit, fold scale below one
    set_all(32'h7fff_ffff, 32'h8000_0000, 1, 0, 32'h0000_8000, 32'h7fff_ffff, 31);
    send_point(32'h8000_0000, 32'h7fff_ffff, 0);
    send_point(32'h0000_0001, 32'hffff_ffff, 32'h1234_5678);
    set_all(0, 0, 0, 32'h7fff_ffff, 32'h0008_0000, 0, 16);
    send_point(32'h7fff_ffff, 32'h0000_0001, 32'h8000_0000);
    send_point(32'h0000_4000, 32'h0000_2000, 32'h0000_1000);
    set_all(0, 0, 0, 32'h0000_0001, 32'h0001_0000, 32'h7fff_ffff, 16);
    send_point(32'h0000_0010, 32'h0000_0020, 32'hffff_fff0);
    set_all(0, 0, 0, 32'h0001_0000, 32'h0008_0000, 32'h7fff_ffff, 16);
    send_point(32'h0000_c000, 32'h0000_a000, 32'h0000_8000);
    // out-of-range index must be ignored
    drain();
    write_reg(reg_idx_t'(3'd7), 32'h0000_0001);
    send_point(32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        if (i % 300 == 0)
          set_all(rand_coord(), rand_coord(), rand_coord(),
                  ($urandom_range(3) == 0) ? $urandom() & 32'h7fff_ffff
                                           : $urandom_range(32'h4000, 32'h4_0000),
                  $urandom_range(32'h1_0000, 32'h8_0000),
                  ($urandom_range(3) == 0) ? $urandom() & 32'h7fff_ffff
                                           : $urandom_range(0, 32'h20_0000),
                  $urandom_range(0, 31));
        else
          set_all(CW'(m_cx), CW'(m_cy), CW'(m_cz), CW'(m_ws), $urandom() & 32'hf_ffff,
                  $urandom(), $urandom_range(0, 20));
      end
      send_point(rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    out_ready = 0;
    m_cx = 0; m_cy = 0; m_cz = 0;
    m_ws = 65536; m_k = 196608; m_bail = 655360; m_iters = 8;
    send_idle = 11;
    recv_idle = 45;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_random(630);
    send_idle = 45;
    recv_idle = 11;
    test_random(630);
    send_idle = 0;
    recv_idle = 0;
    test_random(640);
    drain();
    if (pending_q.size() != 0) begin
      errors++;
      $display("%0d results never arrived", pending_q.size());
    end
    $display("covered %0d points and %0d results across directed and random settings",
             points, results);
    if (errors == 0) begin
      $display("octahedral_fold_fractal_distance_test OK");
    end else begin
      $display("octahedral_fold_fractal_distance_test NOT OK");
    end
    $finish;
  end
endmodule
